// ===== design/pdsh_pkg.sv =====
// Shared types and constants for the packet deframer with sync-word hunt.
package pdsh_pkg;

  localparam int unsigned HeaderBytes  = 32;
  localparam int unsigned LengthOffset = 12;
  localparam int unsigned LengthBytes  = 4;

  localparam int unsigned HdrIdxW = 6;
  localparam logic [HdrIdxW-1:0] HdrLast     = HdrIdxW'(HeaderBytes);
  localparam logic [HdrIdxW-1:0] LenFirstIdx = HdrIdxW'(LengthOffset);
  localparam logic [HdrIdxW-1:0] LenEndIdx   = HdrIdxW'(LengthOffset + LengthBytes);

  localparam logic [55:0] SyncHead = 56'h00_0000_8000_0080;
  localparam logic [7:0]  SyncLast = 8'h7F;
  localparam logic [2:0]  WinFull  = 3'd7;

  localparam logic [15:0] LenAdjReset = 16'd16;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam int unsigned CfgAddrW = 3;
  localparam logic RegLenAdj = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_restart;
    logic       start_hunt;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_end;
    logic       sync_found;
  } out_beat_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== design/pdsh_front.sv =====
// Front end: header absorption, payload counting and sync-word hunting per byte.
module pdsh_front import pdsh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  in_beat_t    in_beat_i,
  input  logic        q_full_i,
  input  logic [15:0] len_adj_i,
  output logic        in_stall_o,
  output logic        push_o,
  output out_beat_t   push_beat_o
);

  logic [HdrIdxW-1:0] hdr_idx_q, hdr_idx_d;
  logic               in_hdr_q, in_hdr_d;
  logic [31:0]        pay_len_q, pay_len_d;
  logic [31:0]        pay_cnt_q, pay_cnt_d;
  logic [55:0]        win_q, win_d;
  logic [2:0]         fill_q, fill_d;
  logic               hunt_q, hunt_d;

  logic               accept;
  logic [HdrIdxW-1:0] idx_e, idx_n;
  logic               in_hdr_e, hunt_e;
  logic [31:0]        cnt_e, cnt_n, len_base, tgt;
  logic [55:0]        win_e;
  logic [2:0]         fill_e;
  logic [32:0]        diff;
  logic [1:0]         k;
  logic               last, found;
  logic [7:0]         b;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign b          = in_beat_i.data_byte;

  always_comb begin
    idx_e    = in_beat_i.file_restart ? '0 : hdr_idx_q;
    in_hdr_e = in_beat_i.file_restart | in_hdr_q;
    cnt_e    = in_beat_i.file_restart ? '0 : pay_cnt_q;
    hunt_e   = in_beat_i.start_hunt | hunt_q;
    win_e    = in_beat_i.start_hunt ? '0 : win_q;
    fill_e   = in_beat_i.start_hunt ? '0 : fill_q;

    idx_n    = idx_e + HdrIdxW'(1);
    len_base = (idx_e == '0) ? '0 : pay_len_q;
    k        = 2'(idx_e - LenFirstIdx);

    // Target count is the header length less the adjustment, floored at one.
    diff  = {1'b0, pay_len_q} - {17'b0, len_adj_i};
    tgt   = (!diff[32] && (diff[31:0] != '0)) ? diff[31:0] : 32'd1;
    cnt_n = cnt_e + 32'd1;
    last  = cnt_n >= tgt;
    found = hunt_e && (fill_e == WinFull) && (win_e == SyncHead) && (b == SyncLast);

    hdr_idx_d   = hdr_idx_q;
    in_hdr_d    = in_hdr_q;
    pay_len_d   = pay_len_q;
    pay_cnt_d   = pay_cnt_q;
    win_d       = win_q;
    fill_d      = fill_q;
    hunt_d      = hunt_q;
    push_o      = 1'b0;
    push_beat_o = '{payload_byte: b, packet_end: last, sync_found: found};

    if (accept) begin
      hunt_d = hunt_e;
      win_d  = win_e;
      fill_d = fill_e;
      if (in_hdr_e) begin
        pay_len_d = len_base;
        if (idx_e >= LenFirstIdx && idx_e < LenEndIdx) begin
          pay_len_d = len_base | ({24'b0, b} << {k, 3'b000});
        end
        if (idx_n >= HdrLast) begin
          hdr_idx_d = '0;
          in_hdr_d  = 1'b0;
          pay_cnt_d = '0;
        end else begin
          hdr_idx_d = idx_n;
          in_hdr_d  = 1'b1;
          pay_cnt_d = cnt_e;
        end
      end else begin
        if (last) begin
          pay_cnt_d = '0;
          in_hdr_d  = 1'b1;
          hdr_idx_d = '0;
        end else begin
          pay_cnt_d = cnt_n;
          in_hdr_d  = 1'b0;
          hdr_idx_d = idx_e;
        end
        if (found) begin
          hunt_d = 1'b0;
          win_d  = '0;
          fill_d = '0;
          push_o = 1'b1;
        end else if (hunt_e) begin
          win_d  = {win_e[47:0], b};
          fill_d = (fill_e == WinFull) ? fill_e : fill_e + 3'd1;
        end else begin
          push_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q <= '0;
      in_hdr_q  <= 1'b1;
      pay_len_q <= '0;
      pay_cnt_q <= '0;
      win_q     <= '0;
      fill_q    <= '0;
      hunt_q    <= 1'b0;
    end else begin
      hdr_idx_q <= hdr_idx_d;
      in_hdr_q  <= in_hdr_d;
      pay_len_q <= pay_len_d;
      pay_cnt_q <= pay_cnt_d;
      win_q     <= win_d;
      fill_q    <= fill_d;
      hunt_q    <= hunt_d;
    end
  end

endmodule

// ===== design/pdsh_queue.sv =====
// Short result queue between the front end and the output stage.
module pdsh_queue import pdsh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_beat_t push_beat_i,
  input  logic      pop_i,
  output out_beat_t pop_beat_o,
  output q_status_t status_o
);

  out_beat_t         mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign pop_beat_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== design/pdsh_back.sv =====
// Back end: output register that drains the queue toward the receiver.
module pdsh_back import pdsh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  out_beat_t q_beat_i,
  output logic      pop_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_beat_t out_beat_o
);

  logic      out_valid_q, out_valid_d;
  out_beat_t out_beat_q;

  // Refill whenever the register is empty or its beat leaves this cycle.
  assign pop_o = !q_status_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_beat_q <= q_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

// ===== design/packet_deframer_sync_hunt.sv =====
// Top level of the packet deframer with sync-word hunt.
//
// The input channel takes one raw stream byte per beat, with file_restart and
// start_hunt flags. Header bytes are absorbed; payload bytes come out on the
// output channel with packet_end on the last byte of each packet. While a
// hunt is active, payload bytes are dropped until the byte that completes the
// sync word, which comes out with sync_found set.
// One byte is taken per clock while in_stall_o is low. Each output beat is
// written into a two-entry queue and then moved into the output register
// that drives out_valid_o.
// When the receiver stalls, the output register holds its beat and the queue
// fills; once it is full, in_stall_o rises until the receiver drains it.
// After reset the block expects header byte 0, no hunt is active, the queue
// is empty and length_adjust is 16. It is written over the APB port at byte
// address 0; the user must write it only while idle, the block does not check.
module packet_deframer_sync_hunt import pdsh_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_beat_t            in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_beat_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [15:0] len_adj_q, len_adj_d;
  logic        cfg_wr;
  logic        fr_push;
  out_beat_t   fr_beat;
  out_beat_t   q_beat;
  q_status_t   q_status;
  logic        q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[CfgAddrW-1] == RegLenAdj);

  always_comb begin
    len_adj_d = len_adj_q;
    if (cfg_wr) begin
      len_adj_d = pwdata[15:0];
    end
  end

  always_comb begin
    unique case (paddr[CfgAddrW-1])
      RegLenAdj: prdata = {16'b0, len_adj_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_adj_q <= LenAdjReset;
    end else begin
      len_adj_q <= len_adj_d;
    end
  end

  pdsh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_beat_i   (in_beat_i),
    .q_full_i    (q_status.full),
    .len_adj_i   (len_adj_q),
    .in_stall_o  (in_stall_o),
    .push_o      (fr_push),
    .push_beat_o (fr_beat)
  );

  pdsh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_push),
    .push_beat_i (fr_beat),
    .pop_i       (q_pop),
    .pop_beat_o  (q_beat),
    .status_o    (q_status)
  );

  pdsh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_beat_i    (q_beat),
    .pop_o       (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> !fr_push)
    else $error("result pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("output stage popped an empty queue");

  a_cfg_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (len_adj_q == $past(pwdata[15:0])))
    else $error("length_adjust write was not taken");

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == q_status.full)
    else $error("input stall does not follow queue occupancy");

endmodule
